[sv/mrcs_pkg.sv]
// Shared types and constants for the matrix row and column sum block.
`timescale 1ns / 1ps
package mrcs_pkg;

   localparam int MaxColumnsDefault = 32;
   localparam int ElemWidth         = 32;
   localparam int IndexWidth        = 16;
   localparam int RowCountWidth     = 16;
   localparam int ColCountWidth     = 6;
   localparam int CsrIndexWidth     = 1;
   localparam int CsrDataWidth      = 16;

   // Register indexes on the write port
   localparam logic [CsrIndexWidth-1:0] CsrRowCount    = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrColumnCount = 1'd1;

   // Result kinds carried on tuser
   localparam logic KindRow    = 1'b0;
   localparam logic KindColumn = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_elem;   // capture the accepted element
      logic rd_en;       // read the column accumulator at the column address
      logic acc_en;      // write back column sum, advance the row sum
      logic row_out;     // load the result register with the row sum
      logic col_out;     // load the result register with the column sum read
      logic col_last;    // this column sum closes the matrix
      logic clear_cols;  // drop every column accumulator back to zero
   } mrcs_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;    // result register can take a new request this cycle
   } mrcs_status_type;

endpackage

[sv/mrcs_ctrl.sv]
// Controller: sequencing, position counters and configuration registers.
`timescale 1ns / 1ps
module mrcs_ctrl #(
   parameter int MAX_COLUMNS = mrcs_pkg::MaxColumnsDefault,
   parameter int CW          = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [mrcs_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [mrcs_pkg::CsrDataWidth-1:0]    csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  mrcs_pkg::mrcs_status_type            status,
   output mrcs_pkg::mrcs_cmd_type               cmd,
   output logic [CW-1:0]                        col_addr,
   output logic [mrcs_pkg::IndexWidth-1:0]      row_index
);
   import mrcs_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ACC  = 2'd1;
   localparam logic [1:0] S_DRD  = 2'd2;
   localparam logic [1:0] S_DWR  = 2'd3;

   localparam logic [ColCountWidth-1:0] MaxCols = ColCountWidth'(MAX_COLUMNS);

   logic [1:0]                 state_ff, state_in;
   logic [RowCountWidth-1:0]   row_count_ff, row_count_in;
   logic [ColCountWidth-1:0]   col_count_ff, col_count_in;
   logic [CW-1:0]              col_pos_ff, col_pos_in;
   logic [IndexWidth-1:0]      row_pos_ff, row_pos_in;
   logic [CW-1:0]              dump_ff, dump_in;

   logic [ColCountWidth-1:0]   cols_eff;
   logic [RowCountWidth-1:0]   rows_eff;
   logic                       row_end, matrix_end, dump_last;

   always_comb begin
      if (col_count_ff == '0) begin
         cols_eff = ColCountWidth'(1);
      end else if (col_count_ff > MaxCols) begin
         cols_eff = MaxCols;
      end else begin
         cols_eff = col_count_ff;
      end
      rows_eff   = (row_count_ff == '0) ? RowCountWidth'(1) : row_count_ff;
      row_end    = !((7'(col_pos_ff) + 7'd1) < 7'(cols_eff));
      matrix_end = !((17'(row_pos_ff) + 17'd1) < 17'(rows_eff));
      dump_last  = ((7'(dump_ff) + 7'd1) == 7'(cols_eff));
   end

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_we) begin
         case (csr_index)
            CsrRowCount:    row_count_in = csr_wdata[RowCountWidth-1:0];
            CsrColumnCount: col_count_in = csr_wdata[ColCountWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      dump_in    = dump_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_elem = 1'b1;
               cmd.rd_en     = 1'b1;
               state_in      = S_ACC;
            end
         end
         S_ACC: begin
            if (!row_end) begin
               cmd.acc_en = 1'b1;
               col_pos_in = col_pos_ff + CW'(1);
               state_in   = S_IDLE;
            end else if (status.out_free) begin
               cmd.acc_en  = 1'b1;
               cmd.row_out = 1'b1;
               col_pos_in  = '0;
               if (matrix_end) begin
                  row_pos_in = '0;
                  dump_in    = '0;
                  state_in   = S_DRD;
               end else begin
                  row_pos_in = row_pos_ff + IndexWidth'(1);
                  state_in   = S_IDLE;
               end
            end
         end
         S_DRD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_DWR;
         end
         S_DWR: begin
            if (status.out_free) begin
               cmd.col_out  = 1'b1;
               cmd.col_last = dump_last;
               if (dump_last) begin
                  cmd.clear_cols = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  dump_in  = dump_ff + CW'(1);
                  state_in = S_DRD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign col_addr  = (state_ff == S_DRD || state_ff == S_DWR) ? dump_ff : col_pos_ff;
   assign row_index = row_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_count_ff <= RowCountWidth'(1);
         col_count_ff <= ColCountWidth'(1);
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         dump_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         dump_ff      <= dump_in;
      end
   end

endmodule

[sv/mrcs_dp.sv]
// Datapath: column accumulator memory, row sum and result register.
`timescale 1ns / 1ps
module mrcs_dp #(
   parameter int MAX_COLUMNS = mrcs_pkg::MaxColumnsDefault,
   parameter int CW          = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mrcs_pkg::mrcs_cmd_type             cmd,
   input  logic [CW-1:0]                      col_addr,
   input  logic [mrcs_pkg::IndexWidth-1:0]    row_index,
   output mrcs_pkg::mrcs_status_type          status,
   input  logic [mrcs_pkg::ElemWidth-1:0]     elem,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic                               out_kind,
   output logic [mrcs_pkg::IndexWidth-1:0]    out_index,
   output logic [mrcs_pkg::ElemWidth-1:0]     out_value,
   output logic                               out_last
);
   import mrcs_pkg::*;

   logic [ElemWidth-1:0]   col_mem [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] valid_ff;
   logic [ElemWidth-1:0]   elem_ff;
   logic [ElemWidth-1:0]   rd_ff;
   logic                   rdv_ff;
   logic [ElemWidth-1:0]   row_acc_ff;
   logic                   out_valid_ff;
   logic                   out_kind_ff, out_last_ff;
   logic [IndexWidth-1:0]  out_index_ff;
   logic [ElemWidth-1:0]   out_value_ff;

   logic [ElemWidth-1:0]   col_old, col_sum, row_sum;

   assign col_old = rdv_ff ? rd_ff : '0;
   assign col_sum = col_old + elem_ff;
   assign row_sum = row_acc_ff + elem_ff;
   assign status.out_free = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (cmd.load_elem) begin
         elem_ff <= elem;
      end
      if (cmd.rd_en) begin
         rd_ff  <= col_mem[col_addr];
         rdv_ff <= valid_ff[col_addr];
      end
      if (cmd.acc_en) begin
         col_mem[col_addr] <= col_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         row_acc_ff <= '0;
      end else begin
         if (cmd.clear_cols) begin
            valid_ff <= '0;
         end else if (cmd.acc_en) begin
            valid_ff[col_addr] <= 1'b1;
         end
         if (cmd.row_out) begin
            row_acc_ff <= '0;
         end else if (cmd.acc_en) begin
            row_acc_ff <= row_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.row_out || cmd.col_out) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_out) begin
         out_kind_ff  <= KindRow;
         out_index_ff <= row_index;
         out_value_ff <= row_sum;
         out_last_ff  <= 1'b0;
      end else if (cmd.col_out) begin
         out_kind_ff  <= KindColumn;
         out_index_ff <= IndexWidth'(col_addr);
         out_value_ff <= col_old;
         out_last_ff  <= cmd.col_last;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_kind  = out_kind_ff;
   assign out_index = out_index_ff;
   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;

endmodule

[sv/matrix_row_col_sums.sv]
// Top level of the matrix row and column sum block.
`timescale 1ns / 1ps
// Takes a row-major matrix of signed 32-bit elements, one element per request,
// with row_count rows (register 0, zero acts as one) and column_count columns
// (register 1, zero acts as one, values above MAX_COLUMNS act as MAX_COLUMNS).
// Each closed row yields a row sum (tuser low, index = row number). The last
// element of a matrix yields its row sum and then every column sum in column
// order (tuser high, index = column number), the last one flagged by tlast.
// All sums wrap in 32-bit two's complement. Column accumulators live in a
// MAX_COLUMNS-deep memory with a registered read port, so an element takes
// two steps: one to read its column accumulator, one to add and write back.
// At a row end the second step also waits until the result register is free.
// The column dump after a matrix reads each column, then loads the result
// register, waiting out any stall from the result side; no element is
// taken meanwhile. Write the registers only while the block is idle.
module matrix_row_col_sums #(
   parameter int MAX_COLUMNS = mrcs_pkg::MaxColumnsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration writes
   input  logic                                csr_we,
   input  logic [mrcs_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [mrcs_pkg::CsrDataWidth-1:0]   csr_wdata,
   // Element requests
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,  // [31:0] element
   // Sum results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [47:0]                         rsp_tdata,  // [15:0] sum_index, [47:16] sum_value
   output logic                                rsp_tuser,  // sum_kind
   output logic                                rsp_tlast   // final_sum
);
   import mrcs_pkg::*;

   localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   mrcs_cmd_type           cmd;
   mrcs_status_type        status;
   logic [CW-1:0]          col_addr;
   logic [IndexWidth-1:0]  row_index;
   logic [IndexWidth-1:0]  out_index;
   logic [ElemWidth-1:0]   out_value;

   // Sequence requests, positions and the end-of-matrix dump
   mrcs_ctrl #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .CW          (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .col_addr   (col_addr),
      .row_index  (row_index)
   );

   // Hold the sums and the result register
   mrcs_dp #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .CW          (CW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .col_addr  (col_addr),
      .row_index (row_index),
      .status    (status),
      .elem      (req_tdata),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_index (out_index),
      .out_value (out_value),
      .out_last  (rsp_tlast)
   );

   // Pack index low, value above it
   assign rsp_tdata = {out_value, out_index};

endmodule

[sv/mrcs_checker.sv]
// Port-level checks for the matrix row and column sum block, bound to the top.
`timescale 1ns / 1ps
module mrcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Only a column sum can close a matrix
   a_last_is_column: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("tlast on a row sum");

   // No element is taken while the column dump is still running
   a_dump_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && !rsp_tlast |-> !req_tready)
      else $error("element taken during column dump");

   // One element at a time: the block is busy right after taking one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("back-to-back element accepted");

endmodule

bind matrix_row_col_sums mrcs_checker u_mrcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[test/tb.sv]
// Self-checking testbench for the matrix row and column sum block.
`timescale 1ns / 1ps
module tb;
   import mrcs_pkg::*;

   localparam int MaxCols      = MaxColumnsDefault;
   localparam int IdleLimit    = 2000;  // cycles with no request or sum accepted
   localparam int HoldCycles   = 400;   // long receiver hold-off
   localparam int SettleCycles = 12;    // margin to finish an element that closes nothing
   localparam int RandomItems  = 115;
   localparam int PrintLimit   = 40;

   // One expected or observed sum
   typedef struct {
      logic                  kind;
      logic [IndexWidth-1:0] index;
      logic [ElemWidth-1:0]  value;
      logic                  last;
   } row_col_sum_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     csr_we     = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index  = '0;
   logic [CsrDataWidth-1:0]  csr_wdata  = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [31:0]              req_tdata  = '0;  // [31:0] element
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [47:0]              rsp_tdata;        // [15:0] sum_index, [47:16] sum_value
   logic                     rsp_tuser;        // sum_kind
   logic                     rsp_tlast;        // final_sum

   // Shadow of the block: register settings, running sums and positions
   logic [RowCountWidth-1:0] rows_setting = 16'd1;
   logic [ColCountWidth-1:0] cols_setting = 6'd1;
   logic [ElemWidth-1:0]     row_total    = '0;
   logic [ElemWidth-1:0]     col_totals [MaxCols] = '{default: '0};
   int                       row_at       = 0;
   int                       col_at       = 0;

   logic [31:0]     element_queue [$];
   row_col_sum_type expected_sums [$];

   int errors       = 0;
   int quiet_cycles = 0;
   int req_wait     = 0;
   int rsp_wait     = 0;
   bit req_idle     = 1'b0;
   bit rsp_idle     = 1'b0;
   int hold_asked   = 0;
   int hold_served  = 0;
   int hold_left    = 0;

   matrix_row_col_sums dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Zero rows act as one
   function automatic int effective_rows();
      return (rows_setting == 0) ? 1 : int'(rows_setting);
   endfunction

   // Zero columns act as one; clamp anything wider than the accumulator memory
   function automatic int effective_columns();
      if (cols_setting == 0) return 1;
      if (cols_setting > MaxCols) return MaxCols;
      return int'(cols_setting);
   endfunction

   // Add one element into the shadow sums and queue whatever sums it closes.
   // Positions survive a register change: a row closes once the column
   // position reaches or passes the last column of the current setting.
   function automatic void accumulate_element(input logic [ElemWidth-1:0] element);
      int              rows_eff;
      int              cols_eff;
      row_col_sum_type s;
      rows_eff = effective_rows();
      cols_eff = effective_columns();
      row_total = row_total + element;
      col_totals[col_at] = col_totals[col_at] + element;
      if (col_at + 1 < cols_eff) begin
         col_at++;
         return;
      end
      s.kind  = KindRow;
      s.index = row_at[IndexWidth-1:0];
      s.value = row_total;
      s.last  = 1'b0;
      expected_sums.push_back(s);
      row_total = '0;
      col_at    = 0;
      if (row_at + 1 < rows_eff) begin
         row_at = (row_at + 1) & 16'hFFFF;
         return;
      end
      // Matrix closed: dump every column in order, flag the final one
      for (int j = 0; j < cols_eff; j++) begin
         s.kind  = KindColumn;
         s.index = j[IndexWidth-1:0];
         s.value = col_totals[j];
         s.last  = (j + 1 == cols_eff);
         expected_sums.push_back(s);
      end
      col_totals = '{default: '0};
      row_at = 0;
   endfunction

   task automatic note_mismatch(input string msg);
      errors++;
      if (errors <= PrintLimit) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // Request driver: hold an element until accepted, then wait a drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            accumulate_element(req_tdata);
            req_wait = req_idle ? $urandom_range(0, 17) : 0;
         end
         if (!req_tvalid || req_tready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_tvalid <= 1'b0;
            end else if (element_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= element_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Sum monitor: check each accepted sum against the oldest expectation,
   // then stall for a drawn gap or for a requested long hold-off
   always @(posedge clock) begin
      row_col_sum_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sums.size() == 0) begin
               note_mismatch($sformatf("unexpected sum kind %0d index %0d value %h",
                                       rsp_tuser, rsp_tdata[15:0], rsp_tdata[47:16]));
            end else begin
               want = expected_sums.pop_front();
               if (rsp_tuser !== want.kind)
                  note_mismatch($sformatf("sum_kind got %b want %b", rsp_tuser, want.kind));
               if (rsp_tdata[15:0] !== want.index)
                  note_mismatch($sformatf("sum_index got %0d want %0d",
                                          rsp_tdata[15:0], want.index));
               if (rsp_tdata[47:16] !== want.value)
                  note_mismatch($sformatf("sum_value (kind %0d index %0d) got %h want %h",
                                          want.kind, want.index, rsp_tdata[47:16],
                                          want.value));
               if (rsp_tlast !== want.last)
                  note_mismatch($sformatf("final_sum (kind %0d index %0d) got %b want %b",
                                          want.kind, want.index, rsp_tlast, want.last));
            end
            rsp_wait = rsp_idle ? $urandom_range(0, 17) : 0;
         end
         if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when neither side moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IdleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // Write one register; the shadow follows at the capturing edge
   task automatic write_register(input logic [CsrIndexWidth-1:0] idx,
                                 input logic [CsrDataWidth-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CsrRowCount)
         rows_setting = data[RowCountWidth-1:0];
      else
         cols_setting = data[ColCountWidth-1:0];
      @(negedge clock);
   endtask

   // Wait until every element went in and every sum came out, then give the
   // block time to finish an element that closes nothing
   task automatic wait_until_idle();
      @(negedge clock);
      while (element_queue.size() > 0 || req_tvalid || expected_sums.size() > 0)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic choose_idling();
      req_idle = $urandom_range(0, 2) != 0;
      rsp_idle = $urandom_range(0, 2) != 0;
   endtask

   // Mostly random words, with the extremes and small signed values mixed in
   function automatic logic [31:0] pick_element();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         4:       return 32'($urandom_range(0, 15)) - 32'd8;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int                      pushed;
      int                      phase;
      int                      total;
      int                      count;
      logic [CsrDataWidth-1:0] rows_word;
      logic [CsrDataWidth-1:0] cols_word;

      pushed = 0;
      phase  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset setting is a 1x1 matrix: every element yields a row and a column sum
      choose_idling();
      element_queue.push_back(32'h0000_0000);
      element_queue.push_back(32'h7FFF_FFFF);
      element_queue.push_back(32'h8000_0000);
      element_queue.push_back(32'hFFFF_FFFF);
      wait_until_idle();

      // 2x3 matrix whose row sums wrap both ways
      write_register(CsrRowCount, 16'd2);
      write_register(CsrColumnCount, 16'd3);
      choose_idling();
      element_queue.push_back(32'h7FFF_FFFF);
      element_queue.push_back(32'h7FFF_FFFF);
      element_queue.push_back(32'h0000_0001);
      element_queue.push_back(32'h8000_0000);
      element_queue.push_back(32'h8000_0000);
      element_queue.push_back(32'hFFFF_FFFF);
      wait_until_idle();

      // Zero rows and zero columns both act as one
      write_register(CsrRowCount, 16'd0);
      write_register(CsrColumnCount, 16'd0);
      choose_idling();
      element_queue.push_back(32'd5);
      element_queue.push_back(-32'sd5);
      wait_until_idle();

      // Shrink the matrix mid-row: the next element closes row and matrix
      write_register(CsrRowCount, 16'd3);
      write_register(CsrColumnCount, 16'd3);
      element_queue.push_back(32'h1234_5678);
      element_queue.push_back(32'hEDCB_A988);
      wait_until_idle();
      write_register(CsrRowCount, 16'd1);
      write_register(CsrColumnCount, 16'd1);
      element_queue.push_back(32'h0000_0100);
      wait_until_idle();

      // Random phases; the first few pin down the widest, tallest and
      // back-pressure cases
      while (pushed < RandomItems) begin
         choose_idling();
         count = 0;
         if (phase == 0) begin
            // all upper data bits set: column register reads 63, acts as the maximum
            write_register(CsrRowCount, 16'd1);
            write_register(CsrColumnCount, 16'hFFFF);
         end else if (phase == 1) begin
            // tallest matrix: leave it open, a later phase closes it
            write_register(CsrRowCount, 16'hFFFF);
            write_register(CsrColumnCount, 16'd2);
            count = 6;
         end else if (phase == 2) begin
            // hold the receiver off while the sender keeps offering 1x1 matrices
            write_register(CsrRowCount, 16'd1);
            write_register(CsrColumnCount, 16'd1);
            req_idle = 1'b0;
            rsp_idle = 1'b0;
            hold_asked++;
            count = 30;
         end else begin
            case ($urandom_range(0, 9))
               0:       rows_word = 16'd0;
               1:       rows_word = 16'hFFFF;
               2:       rows_word = 16'($urandom);
               default: rows_word = 16'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 9))
               0:       cols_word = {10'($urandom), 6'd0};
               1:       cols_word = {10'($urandom), 6'($urandom_range(33, 63))};
               2:       cols_word = 16'd32;
               default: cols_word = {10'($urandom), 6'($urandom_range(1, 6))};
            endcase
            // skip a register now and then so that settings carry over
            if ($urandom_range(0, 3) != 0) write_register(CsrRowCount, rows_word);
            if ($urandom_range(0, 3) != 0) write_register(CsrColumnCount, cols_word);
         end
         if (count == 0) begin
            total = effective_rows() * effective_columns();
            if (total > 48)
               count = $urandom_range(1, 24);
            else if ($urandom_range(0, 4) == 0)
               count = $urandom_range(1, total);  // stop mid-matrix
            else
               count = total * $urandom_range(1, 2);
         end
         // keep the run near its planned length
         if (count > RandomItems - pushed) count = RandomItems - pushed;
         for (int k = 0; k < count; k++) element_queue.push_back(pick_element());
         pushed += count;
         phase++;
         // pause the sender until every expected sum has come back
         wait_until_idle();
      end

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
